FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the date normalizer back stages.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed in date normalizer");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition in date normalizer");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

FILE: sv/dnwm_pkg.sv
// ----------------------------------------------------------------------------
// dnwm_pkg
// Types, constants and calendar tables of the date normalizer.
// ----------------------------------------------------------------------------
package dnwm_pkg;

   // Reciprocal constants for division by small constants.
   // floor(x / 12) = (x * 171) >> 11 for x below 256.
   localparam logic [7:0] MonthRecip   = 8'd171;
   // floor(x / 7) = (x * 293) >> 11 for x below 512.
   localparam logic [8:0] WeekRecipHi  = 9'd293;
   // floor(x / 7) = (x * 37) >> 8 for x below 40.
   localparam logic [5:0] WeekRecipLo  = 6'd37;

   localparam logic [15:0] DaysPerYear   = 16'd365;
   localparam logic [4:0]  HoursPerDay   = 5'd24;
   localparam logic [5:0]  MinutesPerHour = 6'd60;
   localparam logic [3:0]  MonthMarch    = 4'd3;

   // Data handed from the front stages to the back stages.
   typedef struct packed {
      logic [7:0]  day_x;     // day minus one, before wrapping
      logic [3:0]  day_q;     // number of whole months to remove
      logic [4:0]  mlen;      // month length
      logic [3:0]  month;     // normalized month
      logic [6:0]  year;      // year within century
      logic [15:0] dbase;     // days before the first of the month
      logic [8:0]  wsum;      // weekday sum without the day
      logic [4:0]  hour;
      logic [5:0]  minute;
   } mid_type;

   // Length of a month; February gains a day in leap years.
   function automatic logic [4:0] month_len_f(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Scaled reciprocal of the month length, 2^16 / len rounded up.
   function automatic logic [11:0] day_recip_f(input logic [4:0] len);
      logic [11:0] r;
      case (len)
         5'd28:   r = 12'd2341;
         5'd29:   r = 12'd2260;
         5'd30:   r = 12'd2185;
         default: r = 12'd2115;
      endcase
      return r;
   endfunction

   // Days in the year before the first of the month (common year).
   function automatic logic [8:0] days_before_f(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Month offsets of the weekday formula.
   function automatic logic [2:0] wd_offset_f(input logic [3:0] month);
      logic [2:0] o;
      case (month)
         4'd2:    o = 3'd3;
         4'd3:    o = 3'd2;
         4'd4:    o = 3'd5;
         4'd6:    o = 3'd3;
         4'd7:    o = 3'd5;
         4'd8:    o = 3'd1;
         4'd9:    o = 3'd4;
         4'd10:   o = 3'd6;
         4'd11:   o = 3'd2;
         4'd12:   o = 3'd4;
         default: o = 3'd0;
      endcase
      return o;
   endfunction

endpackage

FILE: sv/dnwm_front.sv
// ----------------------------------------------------------------------------
// dnwm_front
// Stages one to three: month folding, year reduction, month length,
// day quotient, weekday partial sum and the day base of the month.
// ----------------------------------------------------------------------------
module dnwm_front import dnwm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [5:0] minute_in,
   input  logic [4:0] hour_in,
   input  logic [7:0] day_in,
   input  logic [7:0] month_in,
   input  logic [7:0] year_in,
   output logic       out_valid,
   input  logic       out_ready,
   output mid_type    out_data
);

   // Per-stage load enables: a stage loads when empty or when it drains.
   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: month minus one and its quotient by twelve, day minus one,
   // year modulo one hundred and the leap flag.
   logic [7:0]  m1_in, x1_in, y8;
   logic [15:0] mprod;
   logic [4:0]  mq1_in;
   logic [6:0]  yr1_in;
   logic        leap1_in;
   logic [7:0]  m1_ff, x1_ff;
   logic [4:0]  mq1_ff;
   logic [6:0]  yr1_ff;
   logic        leap1_ff;
   logic [4:0]  hour1_ff;
   logic [5:0]  min1_ff;

   always_comb begin
      m1_in    = (month_in == 8'd0) ? 8'd0 : month_in - 8'd1;
      mprod    = {8'd0, m1_in} * {8'd0, MonthRecip};
      mq1_in   = mprod[15:11];
      x1_in    = (day_in == 8'd0) ? 8'd0 : day_in - 8'd1;
      if (year_in >= 8'd200) begin
         y8 = year_in - 8'd200;
      end else if (year_in >= 8'd100) begin
         y8 = year_in - 8'd100;
      end else begin
         y8 = year_in;
      end
      yr1_in   = y8[6:0];
      // One hundred is a multiple of four, so the raw year decides.
      leap1_in = (year_in[1:0] == 2'b00);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         m1_ff    <= m1_in;
         mq1_ff   <= mq1_in;
         x1_ff    <= x1_in;
         yr1_ff   <= yr1_in;
         leap1_ff <= leap1_in;
         hour1_ff <= hour_in;
         min1_ff  <= minute_in;
      end
   end

   // Stage 2: final month and the days of all whole years before it.
   logic [7:0]  mq12, mrem;
   logic [3:0]  month2_in;
   logic [15:0] yday2_in;
   logic [7:0]  yr_plus3;
   logic [3:0]  month2_ff;
   logic [15:0] yday2_ff;
   logic [7:0]  x2_ff;
   logic [6:0]  yr2_ff;
   logic        leap2_ff;
   logic [4:0]  hour2_ff;
   logic [5:0]  min2_ff;

   always_comb begin
      mq12      = {3'd0, mq1_ff} * 8'd12;
      mrem      = m1_ff - mq12;
      month2_in = mrem[3:0] + 4'd1;
      yr_plus3  = {1'b0, yr1_ff} + 8'd3;
      yday2_in  = ({9'd0, yr1_ff} * DaysPerYear) + {10'd0, yr_plus3[7:2]};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         month2_ff <= month2_in;
         yday2_ff  <= yday2_in;
         x2_ff     <= x1_ff;
         yr2_ff    <= yr1_ff;
         leap2_ff  <= leap1_ff;
         hour2_ff  <= hour1_ff;
         min2_ff   <= min1_ff;
      end
   end

   // Stage 3: month length and how many lengths fit in the day, the
   // weekday sum over month and year, and the day base of the month.
   logic [4:0]  len3;
   logic [11:0] recip3;
   logic [19:0] qprod;
   logic [7:0]  g3;
   logic        early3;
   logic [15:0] leapfix3;
   mid_type     mid_in, mid_ff;

   always_comb begin
      len3     = month_len_f(month2_ff, leap2_ff);
      recip3   = day_recip_f(len3);
      qprod    = {12'd0, x2_ff} * {8'd0, recip3};
      early3   = (month2_ff < MonthMarch);
      // January and February count from the year before, wrapped to 8 bits.
      g3       = early3 ? ({1'b0, yr2_ff} - 8'd1) : {1'b0, yr2_ff};
      leapfix3 = (!early3 && leap2_ff) ? 16'd1 : 16'd0;

      mid_in.day_x  = x2_ff;
      mid_in.day_q  = qprod[19:16];
      mid_in.mlen   = len3;
      mid_in.month  = month2_ff;
      mid_in.year   = yr2_ff;
      mid_in.dbase  = yday2_ff + {7'd0, days_before_f(month2_ff)} + leapfix3;
      mid_in.wsum   = {6'd0, wd_offset_f(month2_ff)} + {1'b0, g3} + {3'd0, g3[7:2]};
      mid_in.hour   = hour2_ff;
      mid_in.minute = min2_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         mid_ff <= mid_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = mid_ff;

endmodule

FILE: sv/dnwm_back.sv
// ----------------------------------------------------------------------------
// dnwm_back
// Stages four to six: day wrap, weekday and the linear minute count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dnwm_back import dnwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  mid_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [4:0]  day_out,
   output logic [3:0]  month_out,
   output logic [6:0]  year_out,
   output logic [2:0]  weekday,
   output logic [25:0] minute_count
);

   // Per-stage load enables, as in the front stages.
   logic en4, en5, en6;
   logic v4_ff, v5_ff, v6_ff;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Stage 4: day remainder, weekday sum modulo seven, total days.
   logic [8:0]  qlen;
   logic [7:0]  rem8;
   logic [4:0]  rem4;
   logic [17:0] wprod;
   logic [5:0]  wq;
   logic [8:0]  wrem;
   logic [4:0]  day4_ff;
   logic [2:0]  wr4_ff;
   logic [15:0] dtot4_ff;
   logic [3:0]  month4_ff;
   logic [6:0]  year4_ff;
   logic [4:0]  hour4_ff;
   logic [5:0]  min4_ff;

   always_comb begin
      qlen  = {5'd0, in_data.day_q} * {4'd0, in_data.mlen};
      rem8  = in_data.day_x - qlen[7:0];
      rem4  = rem8[4:0];
      wprod = {9'd0, in_data.wsum} * {9'd0, WeekRecipHi};
      wq    = wprod[16:11];
      wrem  = in_data.wsum - ({3'd0, wq} * 9'd7);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         day4_ff   <= rem4 + 5'd1;
         wr4_ff    <= wrem[2:0];
         dtot4_ff  <= in_data.dbase + {11'd0, rem4};
         month4_ff <= in_data.month;
         year4_ff  <= in_data.year;
         hour4_ff  <= in_data.hour;
         min4_ff   <= in_data.minute;
      end
   end

   // Stage 5: add the day into the weekday, hours since the epoch.
   logic [5:0]  t5;
   logic [11:0] tprod;
   logic [5:0]  trem;
   logic [2:0]  wd5;
   logic [19:0] hrs5_in;
   logic [2:0]  wd5_ff;
   logic [19:0] hrs5_ff;
   logic [4:0]  day5_ff;
   logic [3:0]  month5_ff;
   logic [6:0]  year5_ff;
   logic [5:0]  min5_ff;

   always_comb begin
      t5      = {3'd0, wr4_ff} + {1'b0, day4_ff};
      tprod   = {6'd0, t5} * {6'd0, WeekRecipLo};
      trem    = t5 - ({3'd0, tprod[10:8]} * 6'd7);
      // A remainder of zero stands for Sunday.
      wd5     = (trem[2:0] == 3'd0) ? 3'd7 : trem[2:0];
      hrs5_in = ({4'd0, dtot4_ff} * {15'd0, HoursPerDay}) + {15'd0, hour4_ff};
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         wd5_ff    <= wd5;
         hrs5_ff   <= hrs5_in;
         day5_ff   <= day4_ff;
         month5_ff <= month4_ff;
         year5_ff  <= year4_ff;
         min5_ff   <= min4_ff;
      end
   end

   // Stage 6: minutes since the epoch; this is the output register.
   logic [25:0] cnt6_in;
   logic [25:0] cnt6_ff;
   logic [2:0]  wd6_ff;
   logic [4:0]  day6_ff;
   logic [3:0]  month6_ff;
   logic [6:0]  year6_ff;

   assign cnt6_in = ({6'd0, hrs5_ff} * {20'd0, MinutesPerHour}) + {20'd0, min5_ff};

   always_ff @(posedge clock) begin
      if (en6) begin
         cnt6_ff   <= cnt6_in;
         wd6_ff    <= wd5_ff;
         day6_ff   <= day5_ff;
         month6_ff <= month5_ff;
         year6_ff  <= year5_ff;
      end
   end

   assign out_valid    = v6_ff;
   assign day_out      = day6_ff;
   assign month_out    = month6_ff;
   assign year_out     = year6_ff;
   assign weekday      = wd6_ff;
   assign minute_count = cnt6_ff;

   // A delivered result always carries a real weekday and date.
   `ASSERT_ALWAYS(a_weekday_nonzero, clock, reset, v6_ff |-> (wd6_ff != 3'd0))
   `ASSERT_ALWAYS(a_day_range, clock, reset, v6_ff |-> (day6_ff != 5'd0))
   `ASSERT_NEVER(a_month, clock, reset, v6_ff && ((month6_ff == 4'd0) || (month6_ff > 4'd12)))
   `ASSERT_NEVER(a_year_range, clock, reset, v6_ff && (year6_ff > 7'd99))
   // Back pressure only reaches the input when every stage is occupied.
   `ASSERT_ALWAYS(a_full_on_stall, clock, reset, !en4 |-> (v4_ff && v5_ff && v6_ff && !out_ready))

endmodule

FILE: sv/date_normalize_weekday_minute_count.sv
// ----------------------------------------------------------------------------
// date_normalize_weekday_minute_count
// Normalizes a raw timestamp and derives weekday and minute count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  req_*     in         minute, hour, raw day, raw month, raw year
//  rsp_*     out        day, month, year, weekday, minute count
//
//  Six register stages, three front and three back, lie between a
//  request and its result; one request can be accepted in every cycle
//  unless a stall on rsp_tready has filled every stage.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  A stall on rsp_tready fills empty stages first and only then holds off
//  req_tready, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module date_normalize_weekday_minute_count import dnwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // minute_in[5:0], hour_in[10:6], day_in[18:11], month_in[26:19],
   // year_in[34:27], zero padding [39:35]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_out[4:0], month_out[8:5], year_out[15:9], weekday[18:16],
   // minute_count[44:19], zero padding [47:45]
   output logic [47:0] rsp_tdata
);

   mid_type     mid_data;
   logic        mid_valid, mid_ready;
   logic [4:0]  day_out;
   logic [3:0]  month_out;
   logic [6:0]  year_out;
   logic [2:0]  weekday;
   logic [25:0] minute_count;

   // Front stages: folding and tables.
   dnwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .minute_in (req_tdata[5:0]),
      .hour_in   (req_tdata[10:6]),
      .day_in    (req_tdata[18:11]),
      .month_in  (req_tdata[26:19]),
      .year_in   (req_tdata[34:27]),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   // Back stages: day wrap, weekday and minute count.
   dnwm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mid_valid),
      .in_ready     (mid_ready),
      .in_data      (mid_data),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .day_out      (day_out),
      .month_out    (month_out),
      .year_out     (year_out),
      .weekday      (weekday),
      .minute_count (minute_count)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {3'd0, minute_count, weekday, year_out, month_out, day_out};

endmodule
